// ===== rtl/core/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg
// Shared constants, types and helpers of the occupancy word difference block.
// ----------------------------------------------------------------------------
package occ_pkg;

   localparam int CHUNK_EDGE_LOG2 = 4;
   localparam int CHUNK_EDGE      = 1 << CHUNK_EDGE_LOG2;
   localparam int WORDS_PER_CHUNK = 64;
   localparam int CELL_COUNT      = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;

   localparam int WORD_W     = 64;
   localparam int POS_W      = 6;
   localparam int WORD_NUM_W = 6;
   localparam int BIT_W      = WORD_NUM_W + POS_W;
   localparam int BIT_CMP_W  = BIT_W + 1;
   localparam int CHUNK_W    = 12;
   localparam int COORD_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int LIMIT_W    = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_X = 3'd0,
      REG_MAX_X = 3'd1,
      REG_MIN_Y = 3'd2,
      REG_MAX_Y = 3'd3,
      REG_MIN_Z = 3'd4,
      REG_MAX_Z = 3'd5,
      REG_LIMIT = 3'd6
   } occ_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_z;
      logic [LIMIT_W-1:0]        change_limit;
   } occ_cfg_type;

   // One classified item: candidate bits already limited to the chunk.
   typedef struct packed {
      logic                      first;
      logic signed [CHUNK_W-1:0] chunk_x;
      logic signed [CHUNK_W-1:0] chunk_y;
      logic signed [CHUNK_W-1:0] chunk_z;
      logic [WORD_NUM_W-1:0]     word_number;
      logic [WORD_W-1:0]         mask;
   } occ_entry_type;

   typedef struct packed {
      logic busy;
      logic stopped;
   } occ_status_type;

   // chunk * edge + local offset along one axis
   function automatic logic signed [COORD_W-1:0] cell_coord(
      input logic signed [CHUNK_W-1:0]  chunk,
      input logic [CHUNK_EDGE_LOG2-1:0] local_pos
   );
      logic [COORD_W-1:0] base;
      base = {{(COORD_W-CHUNK_W){chunk[CHUNK_W-1]}}, chunk};
      return (base << CHUNK_EDGE_LOG2) + COORD_W'(local_pos);
   endfunction

endpackage

// ===== rtl/core/occ_if.sv =====
// ----------------------------------------------------------------------------
// occ_if
// Valid/ready channels: word pair items in, changed cell items out.
// ----------------------------------------------------------------------------
interface occ_req_if import occ_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      first_of_diff;
   logic signed [CHUNK_W-1:0] chunk_x;
   logic signed [CHUNK_W-1:0] chunk_y;
   logic signed [CHUNK_W-1:0] chunk_z;
   logic [WORD_NUM_W-1:0]     word_number;
   logic [WORD_W-1:0]         old_bits;
   logic [WORD_W-1:0]         new_bits;

   modport source (
      output valid, first_of_diff, chunk_x, chunk_y, chunk_z, word_number,
             old_bits, new_bits,
      input  ready
   );
   modport sink (
      input  valid, first_of_diff, chunk_x, chunk_y, chunk_z, word_number,
             old_bits, new_bits,
      output ready
   );
endinterface

interface occ_rsp_if import occ_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] cell_x;
   logic signed [COORD_W-1:0] cell_y;
   logic signed [COORD_W-1:0] cell_z;
   logic                      last_of_item;
   logic                      limit_passed;

   modport source (
      output valid, cell_x, cell_y, cell_z, last_of_item, limit_passed,
      input  ready
   );
   modport sink (
      input  valid, cell_x, cell_y, cell_z, last_of_item, limit_passed,
      output ready
   );
endinterface

// ===== rtl/core/occ_front.sv =====
// ----------------------------------------------------------------------------
// occ_front
// Accepts word pair items, XORs them and keeps only bits inside the chunk.
// ----------------------------------------------------------------------------
module occ_front import occ_pkg::*; (
   occ_req_if.sink        req,
   output logic           push_valid,
   input  logic           push_ready,
   output occ_entry_type  push_entry
);

   logic [WORD_W-1:0] diff;
   logic [WORD_W-1:0] in_chunk;
   logic              word_ok;

   always_comb begin
      diff    = req.old_bits ^ req.new_bits;
      word_ok = {1'b0, req.word_number} < (WORD_NUM_W + 1)'(WORDS_PER_CHUNK);
      for (int p = 0; p < WORD_W; p++) begin
         in_chunk[p] = {1'b0, req.word_number, POS_W'(p)} < BIT_CMP_W'(CELL_COUNT);
      end
   end

   always_comb begin
      push_entry.first       = req.first_of_diff;
      push_entry.chunk_x     = req.chunk_x;
      push_entry.chunk_y     = req.chunk_y;
      push_entry.chunk_z     = req.chunk_z;
      push_entry.word_number = req.word_number;
      push_entry.mask        = word_ok ? (diff & in_chunk) : '0;
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

// ===== rtl/core/occ_queue.sv =====
// ----------------------------------------------------------------------------
// occ_queue
// Short FIFO of classified items between the front and the bit walker.
// ----------------------------------------------------------------------------
module occ_queue import occ_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  occ_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output occ_entry_type pop_entry
);

   occ_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = fill_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/occ_back.sv =====
// ----------------------------------------------------------------------------
// occ_back
// Walks the changed bits one per cycle while the result register can advance,
// tests the box, counts against the limit and drives the result register.
// One cell is held back so that the last cell of an item can be marked.
// ----------------------------------------------------------------------------
module occ_back import occ_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  occ_cfg_type    cfg,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  occ_entry_type  pop_entry,
   occ_rsp_if.source      rsp,
   output occ_status_type status
);

   // control
   logic               busy_ff, busy_in;
   logic               cand_valid_ff, cand_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic               stopped_ff, stopped_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  mask_ff, mask_in;

   // payload
   logic signed [CHUNK_W-1:0] chunk_x_ff, chunk_x_in;
   logic signed [CHUNK_W-1:0] chunk_y_ff, chunk_y_in;
   logic signed [CHUNK_W-1:0] chunk_z_ff, chunk_z_in;
   logic [WORD_NUM_W-1:0]     word_ff, word_in;
   logic [POS_W-1:0]          cand_pos_ff, cand_pos_in;
   logic signed [COORD_W-1:0] pend_x_ff, pend_x_in;
   logic signed [COORD_W-1:0] pend_y_ff, pend_y_in;
   logic signed [COORD_W-1:0] pend_z_ff, pend_z_in;
   logic                      pend_limit_ff, pend_limit_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   logic signed [COORD_W-1:0] out_z_ff, out_z_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_limit_ff, out_limit_in;

   logic                      advance, load, hit, passed, ending;
   logic [WORD_W-1:0]         lowest;
   logic [POS_W-1:0]          pick_pos;
   logic [BIT_W-1:0]          bit_idx;
   logic signed [COORD_W-1:0] cx, cy, cz;
   logic [COUNT_W-1:0]        count_inc;

   assign advance   = !out_valid_ff || rsp.ready;
   assign pop_ready = advance && !busy_ff;
   assign load      = pop_ready && pop_valid;

   // lowest set bit of what is left
   always_comb begin
      lowest   = mask_ff & (~mask_ff + WORD_W'(1));
      pick_pos = '0;
      for (int p = 0; p < WORD_W; p++) begin
         if (lowest[p]) begin
            pick_pos = pick_pos | POS_W'(p);
         end
      end
   end

   assign bit_idx = {word_ff, cand_pos_ff};
   assign cx = cell_coord(chunk_x_ff, bit_idx[CHUNK_EDGE_LOG2-1:0]);
   assign cy = cell_coord(chunk_y_ff, bit_idx[2*CHUNK_EDGE_LOG2-1:CHUNK_EDGE_LOG2]);
   assign cz = cell_coord(chunk_z_ff, CHUNK_EDGE_LOG2'(bit_idx >> (2 * CHUNK_EDGE_LOG2)));

   assign hit = cand_valid_ff
                && cx >= cfg.min_x && cx <= cfg.max_x
                && cy >= cfg.min_y && cy <= cfg.max_y
                && cz >= cfg.min_z && cz <= cfg.max_z;

   assign count_inc = count_ff + COUNT_W'(1);
   assign passed    = count_inc > COUNT_W'(cfg.change_limit);
   assign ending    = busy_ff && (mask_ff == '0) && !cand_valid_ff;

   always_comb begin
      logic stopped_eff;
      busy_in       = busy_ff;
      cand_valid_in = cand_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      stopped_in    = stopped_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      chunk_x_in    = chunk_x_ff;
      chunk_y_in    = chunk_y_ff;
      chunk_z_in    = chunk_z_ff;
      word_in       = word_ff;
      cand_pos_in   = cand_pos_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_z_in     = pend_z_ff;
      pend_limit_in = pend_limit_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      out_last_in   = out_last_ff;
      out_limit_in  = out_limit_ff;
      stopped_eff   = stopped_ff;

      if (advance) begin
         out_valid_in = 1'b0;
         if (load) begin
            if (pop_entry.first) begin
               count_in    = '0;
               stopped_in  = 1'b0;
               stopped_eff = 1'b0;
            end
            mask_in       = stopped_eff ? '0 : pop_entry.mask;
            busy_in       = !stopped_eff && (pop_entry.mask != '0);
            cand_valid_in = 1'b0;
            chunk_x_in    = pop_entry.chunk_x;
            chunk_y_in    = pop_entry.chunk_y;
            chunk_z_in    = pop_entry.chunk_z;
            word_in       = pop_entry.word_number;
         end else if (busy_ff) begin
            // box test and count of the candidate picked on the previous advance
            if (hit) begin
               count_in = count_inc;
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_x_in     = pend_x_ff;
                  out_y_in     = pend_y_ff;
                  out_z_in     = pend_z_ff;
                  out_last_in  = 1'b0;
                  out_limit_in = pend_limit_ff;
               end
               pend_valid_in = 1'b1;
               pend_x_in     = cx;
               pend_y_in     = cy;
               pend_z_in     = cz;
               pend_limit_in = passed;
               if (passed) begin
                  stopped_in = 1'b1;
               end
            end
            // pick the next bit, or drop the rest once the limit is passed
            if (hit && passed) begin
               mask_in       = '0;
               cand_valid_in = 1'b0;
            end else begin
               cand_valid_in = mask_ff != '0;
               cand_pos_in   = pick_pos;
               mask_in       = mask_ff & ~lowest;
            end
            if (ending) begin
               out_valid_in  = pend_valid_ff;
               out_x_in      = pend_x_ff;
               out_y_in      = pend_y_ff;
               out_z_in      = pend_z_ff;
               out_last_in   = 1'b1;
               out_limit_in  = pend_limit_ff;
               pend_valid_in = 1'b0;
               busy_in       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         cand_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         stopped_ff    <= 1'b0;
         count_ff      <= '0;
         mask_ff       <= '0;
      end else begin
         busy_ff       <= busy_in;
         cand_valid_ff <= cand_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         stopped_ff    <= stopped_in;
         count_ff      <= count_in;
         mask_ff       <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_x_ff    <= chunk_x_in;
      chunk_y_ff    <= chunk_y_in;
      chunk_z_ff    <= chunk_z_in;
      word_ff       <= word_in;
      cand_pos_ff   <= cand_pos_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_z_ff     <= pend_z_in;
      pend_limit_ff <= pend_limit_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_last_ff   <= out_last_in;
      out_limit_ff  <= out_limit_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.cell_x       = out_x_ff;
   assign rsp.cell_y       = out_y_ff;
   assign rsp.cell_z       = out_z_ff;
   assign rsp.last_of_item = out_last_ff;
   assign rsp.limit_passed = out_limit_ff;

   assign status.busy    = busy_ff;
   assign status.stopped = stopped_ff;

endmodule

// ===== rtl/core/occupancy_word_diff_to_cells.sv =====
// Walk: the walker takes one differing bit per cycle while the result register
//   can advance; each cell is held one step to mark the last, and a new item is
//   taken only once the walk of the one before it is done.
// Reset: synchronous, active high; clears the queue, walker, count, stop
//   flag and registers (bounds 0, change_limit 4096).
// ----------------------------------------------------------------------------
// occupancy_word_diff_to_cells
// Turns the XOR of two occupancy words into a stream of changed cells inside
// a bounding box, with a per-diff cap on the number of cells.
// ----------------------------------------------------------------------------
module occupancy_word_diff_to_cells import occ_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   occ_req_if.sink               req,
   occ_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   occ_cfg_type    cfg_ff, cfg_in;
   logic           push_valid, push_ready;
   occ_entry_type  push_entry;
   logic           pop_valid, pop_ready;
   occ_entry_type  pop_entry;
   occ_status_type back_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_X: cfg_in.min_x        = csr_write_data;
            REG_MAX_X: cfg_in.max_x        = csr_write_data;
            REG_MIN_Y: cfg_in.min_y        = csr_write_data;
            REG_MAX_Y: cfg_in.max_y        = csr_write_data;
            REG_MIN_Z: cfg_in.min_z        = csr_write_data;
            REG_MAX_Z: cfg_in.max_z        = csr_write_data;
            REG_LIMIT: cfg_in.change_limit = csr_write_data;
            default:   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x        <= '0;
         cfg_ff.max_x        <= '0;
         cfg_ff.min_y        <= '0;
         cfg_ff.max_y        <= '0;
         cfg_ff.min_z        <= '0;
         cfg_ff.max_z        <= '0;
         cfg_ff.change_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   occ_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   occ_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   occ_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp),
      .status    (back_status)
   );

   a_limit_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.limit_passed |-> rsp.last_of_item)
      else $error("limit cell not marked last");

   a_limit_sets_stop: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.limit_passed |-> back_status.stopped)
      else $error("limit cell shown without stop flag");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp.valid && !back_status.busy)
      else $error("walker or result not idle after reset");

   a_idle_no_cell: assert property (@(posedge clock) disable iff (reset)
      !back_status.busy && !rsp.valid |=> !rsp.valid)
      else $error("cell produced while walker idle");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds old/new occupancy word pairs into occupancy_word_diff_to_cells under
// random source gaps and sink stalls, and checks every changed cell against
// typed cells or a behavioural prediction of the XOR walk, the box test and the diff cap.
// ----------------------------------------------------------------------------
module testbench;
   import occ_pkg::*;

   localparam int SETTLE_CYCLES = 220;
   localparam int QUIET_LIMIT   = 2000;
   localparam int MAX_IDLE      = 14;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 38;
   localparam logic [COORD_W-1:0] CMIN = 16'h8000;
   localparam logic [COORD_W-1:0] CMAX = 16'h7FFF;

   typedef struct {
      logic                      first;
      logic signed [CHUNK_W-1:0] cx;
      logic signed [CHUNK_W-1:0] cy;
      logic signed [CHUNK_W-1:0] cz;
      logic [WORD_NUM_W-1:0]     word;
      logic [WORD_W-1:0]         old_w;
      logic [WORD_W-1:0]         new_w;
   } word_pair_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
      logic                      limit;
   } cell_type;

   typedef enum int {SET_RESET, SET_WIDE, SET_CAP0, SET_EMPTY, SET_CAP3} setting_type;
   typedef enum int {BY_MODEL, NO_CELLS, ONE_CELL} row_check_type;

   typedef struct {
      setting_type   setting;
      word_pair_type w;
      row_check_type check;
      cell_type      typed_cell;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   occ_req_if req_ch ();
   occ_rsp_if rsp_ch ();

   occupancy_word_diff_to_cells DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   occ_cfg_type          box_cfg;
   logic [COUNT_W-1:0]   diff_count;
   logic                 diff_stopped;
   cell_type             pending_cells[$];
   int                   mismatches = 0;
   int                   quiet_cycles = 0;
   bit                   src_quiet = 1'b0;
   bit                   snk_quiet = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // changed cells of one word pair; advances the running count and stop flag
   function automatic void predict_cells(input word_pair_type w, output cell_type cells[$]);
      logic [WORD_W-1:0] flips;
      int                bitno;
      int                p;
      int                x;
      int                y;
      int                z;
      cell_type          c;
      cells = {};
      flips = w.old_w ^ w.new_w;
      if (w.first) begin
         diff_count   = '0;
         diff_stopped = 1'b0;
      end
      if (diff_stopped || int'(w.word) >= WORDS_PER_CHUNK) return;
      for (p = 0; p < WORD_W && !diff_stopped; p++) begin
         if (!flips[p]) continue;
         bitno = int'(w.word) * WORD_W + p;
         if (bitno >= CELL_COUNT) continue;
         x = int'(w.cx) * CHUNK_EDGE + bitno % CHUNK_EDGE;
         y = int'(w.cy) * CHUNK_EDGE + (bitno % (CHUNK_EDGE * CHUNK_EDGE)) / CHUNK_EDGE;
         z = int'(w.cz) * CHUNK_EDGE + bitno / (CHUNK_EDGE * CHUNK_EDGE);
         if (x < int'(box_cfg.min_x) || x > int'(box_cfg.max_x) ||
             y < int'(box_cfg.min_y) || y > int'(box_cfg.max_y) ||
             z < int'(box_cfg.min_z) || z > int'(box_cfg.max_z)) continue;
         diff_count = diff_count + 1'b1;
         c.x     = x[COORD_W-1:0];
         c.y     = y[COORD_W-1:0];
         c.z     = z[COORD_W-1:0];
         c.last  = 1'b0;
         c.limit = 1'b0;
         if (diff_count > {1'b0, box_cfg.change_limit}) begin
            c.limit      = 1'b1;
            diff_stopped = 1'b1;
         end
         cells = {cells, c};
      end
      if (cells.size() != 0) cells[cells.size() - 1].last = 1'b1;
   endfunction

   function automatic occ_cfg_type setting_cfg(input setting_type s);
      occ_cfg_type c;
      c = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, LIMIT_RESET};
      case (s)
         SET_WIDE, SET_CAP0: begin
            c = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 16'hFFFF};
            if (s == SET_CAP0) c.change_limit = '0;
         end
         SET_EMPTY: c = '{16'h1, 16'h0, CMIN, CMAX, CMIN, CMAX, LIMIT_RESET};
         SET_CAP3:  c = '{16'h0, 16'hF, 16'h0, 16'hF, 16'h0, 16'hF, 16'h3};
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input int v);
      if (v < -32768) return CMIN;
      if (v > 32767) return CMAX;
      return v[COORD_W-1:0];
   endfunction

   // random span around one chunk, clipped to the coordinate range
   function automatic logic [2*COORD_W-1:0] box_span(input logic signed [CHUNK_W-1:0] c);
      int lo;
      int hi;
      lo = int'(c) * CHUNK_EDGE + int'($urandom_range(0, 24)) - 16;
      hi = lo + int'($urandom_range(0, 40));
      return {clamp_coord(lo), clamp_coord(hi)};
   endfunction

   task automatic csr_put(input occ_reg_type r, input logic [CSR_DATA_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= r;
      csr_write_data   <= v;
      @(posedge clock);
   endtask

   task automatic write_setting(input occ_cfg_type c);
      csr_put(REG_MIN_X, c.min_x);
      csr_put(REG_MAX_X, c.max_x);
      csr_put(REG_MIN_Y, c.min_y);
      csr_put(REG_MAX_Y, c.max_y);
      csr_put(REG_MIN_Z, c.min_z);
      csr_put(REG_MAX_Z, c.max_z);
      csr_put(REG_LIMIT, c.change_limit);
      csr_write_enable <= 1'b0;
      box_cfg = c;
   endtask

   task automatic push_item(input word_pair_type w, input row_check_type check,
                            input cell_type tc);
      cell_type got[$];
      int       gap;
      gap = src_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.first_of_diff <= w.first;
      req_ch.chunk_x       <= w.cx;
      req_ch.chunk_y       <= w.cy;
      req_ch.chunk_z       <= w.cz;
      req_ch.word_number   <= w.word;
      req_ch.old_bits      <= w.old_w;
      req_ch.new_bits      <= w.new_w;
      do @(posedge clock); while (!req_ch.ready);
      predict_cells(w, got);
      if (check != BY_MODEL) begin
         got = {};
         if (check == ONE_CELL) got = {tc};
      end
      foreach (got[i]) pending_cells = {pending_cells, got[i]};
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_cells.size() != 0);
   endtask

   // items that emit nothing may still be walking once the queue is empty
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : cell_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = snk_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin : check_cells
      cell_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_cells.size() == 0) begin
            mismatches++;
            $display("%0t: expected no cell, got x=%0d y=%0d z=%0d last=%0b limit=%0b",
                     $time, rsp_ch.cell_x, rsp_ch.cell_y, rsp_ch.cell_z,
                     rsp_ch.last_of_item, rsp_ch.limit_passed);
         end else begin
            want = pending_cells.pop_front();
            if (rsp_ch.cell_x !== want.x || rsp_ch.cell_y !== want.y ||
                rsp_ch.cell_z !== want.z || rsp_ch.last_of_item !== want.last ||
                rsp_ch.limit_passed !== want.limit) begin
               mismatches++;
               $display({"%0t: expected x=%0d y=%0d z=%0d last=%0b limit=%0b, ",
                         "got x=%0d y=%0d z=%0d last=%0b limit=%0b"},
                        $time, want.x, want.y, want.z, want.last, want.limit,
                        rsp_ch.cell_x, rsp_ch.cell_y, rsp_ch.cell_z,
                        rsp_ch.last_of_item, rsp_ch.limit_passed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("occupancy_word_diff_to_cells: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type              dir_rows [21];
      setting_type               cur_setting;
      occ_cfg_type               cfg;
      word_pair_type             w;
      logic signed [CHUNK_W-1:0] cc_x;
      logic signed [CHUNK_W-1:0] cc_y;
      logic signed [CHUNK_W-1:0] cc_z;
      logic [WORD_W-1:0]         flips;
      int                        phase;
      int                        sent;
      int                        seq_len;
      int                        k;
      int                        kind;

      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.first_of_diff <= 1'b0;
      req_ch.chunk_x       <= '0;
      req_ch.chunk_y       <= '0;
      req_ch.chunk_z       <= '0;
      req_ch.word_number   <= '0;
      req_ch.old_bits      <= '0;
      req_ch.new_bits      <= '0;
      box_cfg      = setting_cfg(SET_RESET);
      diff_count   = '0;
      diff_stopped = 1'b0;

      // after reset the box holds only the origin cell
      dir_rows = '{
         '{SET_RESET, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd0, 64'h0, 64'h1},
           ONE_CELL, '{16'h0, 16'h0, 16'h0, 1'b1, 1'b0}},
         '{SET_RESET, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd0, '1, '1}, NO_CELLS, '0},
         '{SET_RESET, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd0, 64'h0, '1},
           ONE_CELL, '{16'h0, 16'h0, 16'h0, 1'b1, 1'b0}},
         '{SET_RESET, '{1'b0, 12'hFFF, 12'h000, 12'h000, 6'd0, 64'h0, 64'h1}, NO_CELLS, '0},
         '{SET_RESET, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd63, '1, 64'h0}, NO_CELLS, '0},
         '{SET_WIDE, '{1'b1, 12'h800, 12'h800, 12'h800, 6'd0, 64'h0, 64'h1},
           ONE_CELL, '{CMIN, CMIN, CMIN, 1'b1, 1'b0}},
         '{SET_WIDE, '{1'b0, 12'h7FF, 12'h7FF, 12'h7FF, 6'd63, 64'h8000_0000_0000_0000, 64'h0},
           ONE_CELL, '{CMAX, CMAX, CMAX, 1'b1, 1'b0}},
         '{SET_WIDE, '{1'b0, 12'h7FF, 12'h800, 12'h005, 6'd17, 64'h0, '1}, BY_MODEL, '0},
         '{SET_WIDE, '{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 6'd42, 64'hA5A5_A5A5_A5A5_A5A5,
           64'h5A5A_5A5A_5A5A_5A5A}, BY_MODEL, '0},
         '{SET_WIDE, '{1'b0, 12'h003, 12'hFF9, 12'h064, 6'd5, 64'h8000_0000_0000_0001,
           64'h8000_0000_0000_0001}, NO_CELLS, '0},
         '{SET_WIDE, '{1'b0, 12'h555, 12'hAAA, 12'h000, 6'd33, 64'h0123_4567_89AB_CDEF,
           64'hFEDC_BA98_7654_3210}, BY_MODEL, '0},
         '{SET_CAP0, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd0, 64'h0, 64'h3},
           ONE_CELL, '{16'h0, 16'h0, 16'h0, 1'b1, 1'b1}},
         '{SET_CAP0, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd1, 64'h0, '1}, NO_CELLS, '0},
         '{SET_CAP0, '{1'b1, 12'h001, 12'h002, 12'h003, 6'd0, 64'h0, 64'h8000_0000_0000_0000},
           ONE_CELL, '{16'd31, 16'd35, 16'd48, 1'b1, 1'b1}},
         '{SET_EMPTY, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd0, 64'h0, '1}, NO_CELLS, '0},
         '{SET_EMPTY, '{1'b0, 12'h005, 12'h005, 12'h005, 6'd7, '1, 64'h0}, NO_CELLS, '0},
         '{SET_CAP3, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd0, 64'h0, '1}, BY_MODEL, '0},
         '{SET_CAP3, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd1, 64'h0, 64'h1}, NO_CELLS, '0},
         '{SET_CAP3, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd0, 64'hF0, 64'h0F}, BY_MODEL, '0},
         '{SET_CAP3, '{1'b1, 12'h000, 12'h000, 12'h000, 6'd60, 64'h0, 64'h3}, BY_MODEL, '0},
         '{SET_CAP3, '{1'b0, 12'h000, 12'h000, 12'h000, 6'd61, 64'h0,
           64'h4000_0000_0000_0001}, BY_MODEL, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_setting = SET_RESET;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].setting != cur_setting) begin
            settle();
            write_setting(setting_cfg(dir_rows[i].setting));
            cur_setting = dir_rows[i].setting;
         end
         push_item(dir_rows[i].w, dir_rows[i].check, dir_rows[i].typed_cell);
      end

      // each phase: a box around one chunk, then diffs of nearby and some random chunk words
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         cc_x = CHUNK_W'($urandom);
         cc_y = CHUNK_W'($urandom);
         cc_z = CHUNK_W'($urandom);
         {cfg.min_x, cfg.max_x} = box_span(cc_x);
         {cfg.min_y, cfg.max_y} = box_span(cc_y);
         {cfg.min_z, cfg.max_z} = box_span(cc_z);
         if ($urandom_range(0, 7) == 0) {cfg.min_z, cfg.max_z} = {cfg.max_z, cfg.min_z};
         case ($urandom_range(0, 5))
            0: cfg.change_limit = '0;
            1: cfg.change_limit = '1;
            2, 3: cfg.change_limit = LIMIT_W'($urandom_range(1, 40));
            default: cfg.change_limit = LIMIT_W'($urandom);
         endcase
         settle();
         write_setting(cfg);
         src_quiet = ($urandom_range(0, 3) == 0);
         snk_quiet = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            seq_len = $urandom_range(1, 8);
            for (k = 0; k < seq_len; k++) begin
               kind    = $urandom_range(0, 9);
               w.first = (k == 0);
               w.cx    = cc_x + CHUNK_W'($urandom_range(0, 2)) - CHUNK_W'(1);
               w.cy    = cc_y + CHUNK_W'($urandom_range(0, 2)) - CHUNK_W'(1);
               w.cz    = cc_z + CHUNK_W'($urandom_range(0, 2)) - CHUNK_W'(1);
               w.word  = WORD_NUM_W'($urandom);
               w.old_w = {$urandom, $urandom};
               flips   = '0;
               case (kind)
                  0: begin
                     w.first = 1'($urandom);
                     w.cx    = CHUNK_W'($urandom);
                     w.cy    = CHUNK_W'($urandom);
                     w.cz    = CHUNK_W'($urandom);
                     flips   = {$urandom, $urandom};
                  end
                  1: flips = {$urandom, $urandom};
                  2: ;
                  default: begin
                     repeat ($urandom_range(1, 4)) flips[$urandom_range(0, WORD_W - 1)] = 1'b1;
                  end
               endcase
               w.new_w = w.old_w ^ flips;
               push_item(w, BY_MODEL, '0);
               sent++;
            end
            if ($urandom_range(0, 4) == 0) drain();
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("occupancy_word_diff_to_cells: match");
      end else begin
         $display("occupancy_word_diff_to_cells: mismatch");
      end
      $finish;
   end

endmodule
